// ===== hdl/plbu_pkg.sv =====
`timescale 1ns / 1ps
package plbu_pkg;

  localparam int BOOK_DEPTH_DEF = 10;
  localparam int PRICE_W = 64;
  localparam int QTY_W = 31;
  localparam int LEVEL_W = 8;
  localparam int OP_W = 3;
  localparam int STATUS_W = 3;
  localparam int LEVELS_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_UPDATE   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_DEL_FROM = 3'd3,
    OP_DEL_THRU = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_THRU     = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  // Command broadcast to every cell of one ladder.
  typedef struct packed {
    logic               insert;
    logic               update;
    logic               remove;
    logic [LEVEL_W-1:0] idx;
  } cell_cmd_t;

endpackage

// ===== hdl/price_level_book_update_top.sv =====
`timescale 1ns / 1ps
// A result is registered and is valid in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle; every cell of a ladder shifts,
// loads or holds together on each accept, so the next message may follow at once.
// Input stalls only while a finished result is held and stalled downstream.
// Reset (rst_n, synchronous, active low) empties both ladders and drops any
// pending result; price and quantity cells are not cleared.
module price_level_book_update_top
  import plbu_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            in_operation,
  input  logic                       in_side,
  input  logic [LEVEL_W-1:0]         in_level,
  input  logic signed [PRICE_W-1:0]  in_price,
  input  logic [QTY_W-1:0]           in_quantity,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [LEVELS_W-1:0]        out_bid_levels,
  output logic [LEVELS_W-1:0]        out_ask_levels,
  output logic                       out_book_empty,
  output logic signed [PRICE_W-1:0]  out_best_bid_price,
  output logic [QTY_W-1:0]           out_best_bid_quantity,
  output logic signed [PRICE_W-1:0]  out_best_ask_price,
  output logic [QTY_W-1:0]           out_best_ask_quantity
);

  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  logic [CW-1:0]   bid_cnt_r, bid_cnt_nxt, ask_cnt_r, ask_cnt_nxt;
  logic [CW-1:0]   cnt, cnt_nxt;
  logic            out_valid_r;
  status_t         status_r, status_nxt;
  logic            accept;
  logic [LEVEL_W-1:0] idx;
  logic            lvl_ok, held_lvl, add_ok, full, match;
  logic            do_insert, do_update, do_remove;
  cell_cmd_t       bid_cmd, ask_cmd;
  logic [BOOK_DEPTH-1:0] bid_match, ask_match;
  logic signed [PRICE_W-1:0] bid_top_price, ask_top_price;
  logic [QTY_W-1:0]          bid_top_qty, ask_top_qty;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign cnt      = in_side ? ask_cnt_r : bid_cnt_r;
  assign idx      = in_level - LEVEL_W'(1);
  assign lvl_ok   = (in_level != '0) && (in_level <= LEVEL_W'(BOOK_DEPTH));
  assign held_lvl = lvl_ok && (idx < LEVEL_W'(cnt));
  assign add_ok   = lvl_ok && (idx <= LEVEL_W'(cnt));
  assign full     = (cnt == CW'(BOOK_DEPTH));
  assign match    = in_side ? ask_match[IW'(idx)] : bid_match[IW'(idx)];

  always_comb begin
    status_nxt  = ST_OK;
    cnt_nxt     = cnt;
    do_insert   = 1'b0;
    do_update   = 1'b0;
    do_remove   = 1'b0;
    bid_cnt_nxt = bid_cnt_r;
    ask_cnt_nxt = ask_cnt_r;
    unique case (in_operation) inside
      OP_ADD: begin
        if (!add_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          do_insert  = 1'b1;
          status_nxt = full ? ST_DROPPED : ST_OK;
          if (!full) cnt_nxt = cnt + CW'(1);
        end
      end
      OP_UPDATE, OP_DELETE: begin
        if (!held_lvl) begin
          status_nxt = ST_RANGE;
        end else if (!match) begin
          status_nxt = ST_MISMATCH;
        end else if (in_operation == OP_UPDATE) begin
          do_update = 1'b1;
        end else begin
          do_remove = 1'b1;
          cnt_nxt   = cnt - CW'(1);
        end
      end
      OP_DEL_FROM: begin
        if (!held_lvl) status_nxt = ST_RANGE;
        else           cnt_nxt    = CW'(idx);
      end
      OP_DEL_THRU: begin
        if (in_level != LEVEL_W'(1)) status_nxt = ST_THRU;
        else                         cnt_nxt    = '0;
      end
      default: ;
    endcase
    if (in_operation == OP_CLEAR) begin
      bid_cnt_nxt = '0;
      ask_cnt_nxt = '0;
    end else if (in_side) begin
      ask_cnt_nxt = cnt_nxt;
    end else begin
      bid_cnt_nxt = cnt_nxt;
    end
  end

  always_comb begin
    bid_cmd.insert = accept & ~in_side & do_insert;
    bid_cmd.update = accept & ~in_side & do_update;
    bid_cmd.remove = accept & ~in_side & do_remove;
    bid_cmd.idx    = idx;
    ask_cmd.insert = accept & in_side & do_insert;
    ask_cmd.update = accept & in_side & do_update;
    ask_cmd.remove = accept & in_side & do_remove;
    ask_cmd.idx    = idx;
  end

  plbu_ladder #(.BOOK_DEPTH(BOOK_DEPTH)) u_bid (
    .clk       (clk),
    .cmd       (bid_cmd),
    .in_price  (in_price),
    .in_qty    (in_quantity),
    .top_price (bid_top_price),
    .top_qty   (bid_top_qty),
    .match_vec (bid_match)
  );

  plbu_ladder #(.BOOK_DEPTH(BOOK_DEPTH)) u_ask (
    .clk       (clk),
    .cmd       (ask_cmd),
    .in_price  (in_price),
    .in_qty    (in_quantity),
    .top_price (ask_top_price),
    .top_qty   (ask_top_qty),
    .match_vec (ask_match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        bid_cnt_r   <= bid_cnt_nxt;
        ask_cnt_r   <= ask_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) status_r <= status_nxt;
  end

  // book state only moves on accept, so it doubles as the result payload
  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_bid_levels        = LEVELS_W'(bid_cnt_r);
  assign out_ask_levels        = LEVELS_W'(ask_cnt_r);
  assign out_book_empty        = (bid_cnt_r == '0) && (ask_cnt_r == '0);
  assign out_best_bid_price    = (bid_cnt_r != '0) ? bid_top_price : '0;
  assign out_best_bid_quantity = (bid_cnt_r != '0) ? bid_top_qty : '0;
  assign out_best_ask_price    = (ask_cnt_r != '0) ? ask_top_price : '0;
  assign out_best_ask_quantity = (ask_cnt_r != '0) ? ask_top_qty : '0;

endmodule

// ===== hdl/plbu_cell.sv =====
`timescale 1ns / 1ps
module plbu_cell
  import plbu_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic signed [PRICE_W-1:0] in_price,
  input  logic [QTY_W-1:0]          in_qty,
  input  logic signed [PRICE_W-1:0] prev_price,
  input  logic [QTY_W-1:0]          prev_qty,
  input  logic signed [PRICE_W-1:0] next_price,
  input  logic [QTY_W-1:0]          next_qty,
  output logic signed [PRICE_W-1:0] price,
  output logic [QTY_W-1:0]          qty,
  output logic                      match
);

  logic signed [PRICE_W-1:0] price_r, price_nxt;
  logic [QTY_W-1:0]          qty_r, qty_nxt;
  logic                      at_idx, past_idx;

  assign at_idx   = (cmd.idx == LEVEL_W'(POS));
  assign past_idx = (LEVEL_W'(POS) > cmd.idx);

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    if (cmd.insert) begin
      if (at_idx) begin
        price_nxt = in_price;
        qty_nxt   = in_qty;
      end else if (past_idx) begin
        price_nxt = prev_price;
        qty_nxt   = prev_qty;
      end
    end else if (cmd.update) begin
      if (at_idx) qty_nxt = in_qty;
    end else if (cmd.remove) begin
      if (at_idx || past_idx) begin
        price_nxt = next_price;
        qty_nxt   = next_qty;
      end
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

  assign price = price_r;
  assign qty   = qty_r;
  assign match = (price_r == in_price);

endmodule

// ===== hdl/plbu_ladder.sv =====
`timescale 1ns / 1ps
module plbu_ladder
  import plbu_pkg::*;
#(
  parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic signed [PRICE_W-1:0] in_price,
  input  logic [QTY_W-1:0]          in_qty,
  output logic signed [PRICE_W-1:0] top_price,
  output logic [QTY_W-1:0]          top_qty,
  output logic [BOOK_DEPTH-1:0]     match_vec
);

  logic signed [PRICE_W-1:0] price_a [BOOK_DEPTH];
  logic [QTY_W-1:0]          qty_a   [BOOK_DEPTH];

  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    logic signed [PRICE_W-1:0] prev_p, next_p;
    logic [QTY_W-1:0]          prev_q, next_q;

    // ends of the chain fold back on the input or on the cell itself
    if (g == 0) begin : g_first
      assign prev_p = in_price;
      assign prev_q = in_qty;
    end else begin : g_mid_prev
      assign prev_p = price_a[g-1];
      assign prev_q = qty_a[g-1];
    end
    if (g == BOOK_DEPTH - 1) begin : g_last
      assign next_p = price_a[g];
      assign next_q = qty_a[g];
    end else begin : g_mid_next
      assign next_p = price_a[g+1];
      assign next_q = qty_a[g+1];
    end

    plbu_cell #(.POS(g)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .in_price   (in_price),
      .in_qty     (in_qty),
      .prev_price (prev_p),
      .prev_qty   (prev_q),
      .next_price (next_p),
      .next_qty   (next_q),
      .price      (price_a[g]),
      .qty        (qty_a[g]),
      .match      (match_vec[g])
    );
  end

  assign top_price = price_a[0];
  assign top_qty   = qty_a[0];

endmodule

// ===== hdl/plbu_checker.sv =====
`timescale 1ns / 1ps
module plbu_checker
  import plbu_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [OP_W-1:0]           in_operation,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [STATUS_W-1:0]       out_status,
  input logic [LEVELS_W-1:0]       out_bid_levels,
  input logic [LEVELS_W-1:0]       out_ask_levels,
  input logic                      out_book_empty,
  input logic signed [PRICE_W-1:0] out_best_bid_price,
  input logic [QTY_W-1:0]          out_best_bid_quantity,
  input logic signed [PRICE_W-1:0] out_best_ask_price,
  input logic [QTY_W-1:0]          out_best_ask_quantity
);

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_book_empty == ((out_bid_levels == '0) && (out_ask_levels == '0))))
    else $error("book_empty disagrees with level counts");

  a_empty_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bid_levels == '0) |->
      (out_best_bid_price == '0 && out_best_bid_quantity == '0))
    else $error("empty bid side shows a best level");

  a_empty_ask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ask_levels == '0) |->
      (out_best_ask_price == '0 && out_best_ask_quantity == '0))
    else $error("empty ask side shows a best level");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_CLEAR) |=>
      (out_valid && out_book_empty && out_status == ST_OK))
    else $error("clear transaction did not empty the book");

  a_stall_holds_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind price_level_book_update_top plbu_checker u_plbu_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .in_operation          (in_operation),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_status            (out_status),
  .out_bid_levels        (out_bid_levels),
  .out_ask_levels        (out_ask_levels),
  .out_book_empty        (out_book_empty),
  .out_best_bid_price    (out_best_bid_price),
  .out_best_bid_quantity (out_best_bid_quantity),
  .out_best_ask_price    (out_best_ask_price),
  .out_best_ask_quantity (out_best_ask_quantity)
);
